// ----- hw/rtl/qgm_pkg.sv -----
// qgm_pkg: shared types and codes of the quadrature gram matrix block
// no dependencies; used by qgm_ctrl, qgm_dp, quadrature_gram_matrix and the testbench
package qgm_pkg;

  localparam int ENTRY_W = 52;
  localparam int VAL_W   = 16;

  typedef enum logic [1:0] {
    CMD_WEIGHT  = 2'd0,
    CMD_FIRST   = 2'd1,
    CMD_SECOND  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_NUM_ROWS  = 2'd0,
    CFG_NUM_COLS  = 2'd1,
    CFG_NUM_NODES = 2'd2,
    CFG_SYMMETRIC = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [2:0]        member;
    logic [3:0]        node;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]                row;
    logic [2:0]                col;
    logic signed [ENTRY_W-1:0] entry;
    logic                      last;
  } rsp_t;

  typedef struct packed {
    logic [3:0] num_rows;
    logic [3:0] num_cols;
    logic [4:0] num_nodes;
    logic       symmetric;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       store_wr;   // store write request accepted this cycle
    logic       issue;      // read one node of the current entry
    logic       acc_clear;  // start of a new entry
    logic [2:0] first_mbr;
    logic [2:0] second_mbr;
    logic [4:0] node;
    logic       emit;       // load result register
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;      // products still in flight
    logic out_free;  // result register can take a new entry
  } dp_stat_t;

endpackage

// ----- hw/rtl/qgm_ram.sv -----
// qgm_ram: generic single write port, single read port ram, registered read
// no dependencies
module qgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/qgm_ctrl.sv -----
// qgm_ctrl: sequencer walking rows, columns and nodes of a compute request
// depends on qgm_pkg
module qgm_ctrl #(
  parameter int MAX_MEMBERS = 8,
  parameter int MAX_NODES   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  qgm_pkg::cmd_t      req_cmd,
  input  qgm_pkg::cfg_t      cfg,
  input  qgm_pkg::dp_stat_t  stat,
  output qgm_pkg::ctl_cmd_t  ctl
);

  localparam int DIM_LIMIT = (MAX_MEMBERS < 8) ? MAX_MEMBERS : 8;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [2:0] r, r_next, c, c_next;
  logic [4:0] n, n_next;
  logic [3:0] rows, cols;
  logic [4:0] nodes;
  logic       sym;
  logic       accept, start, mirror, last_node, last_col, last_entry, emit;

  function automatic logic [3:0] clamp_dim(input logic [3:0] v);
    logic [3:0] res;
    if (v == 4'd0) begin
      res = 4'd1;
    end else if (int'(v) > DIM_LIMIT) begin
      res = 4'(DIM_LIMIT);
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign start      = accept && (req_cmd == qgm_pkg::CMD_COMPUTE);
  assign mirror     = sym && (c < r);
  assign last_node  = (n == nodes - 5'd1);
  assign last_col   = ({1'b0, c} == cols - 4'd1);
  assign last_entry = last_col && ({1'b0, r} == rows - 4'd1);
  assign emit       = (state == S_DRAIN) && !stat.busy && stat.out_free;

  always_comb begin
    ctl.store_wr   = accept && (req_cmd != qgm_pkg::CMD_COMPUTE);
    ctl.issue      = (state == S_ISSUE);
    ctl.acc_clear  = (state == S_ISSUE) && (n == 5'd0);
    ctl.first_mbr  = mirror ? c : r;
    ctl.second_mbr = mirror ? r : c;
    ctl.node       = n;
    ctl.emit       = emit;
    ctl.row        = r;
    ctl.col        = c;
    ctl.last       = last_entry;
  end

  always_comb begin
    state_next = state;
    r_next     = r;
    c_next     = c;
    n_next     = n;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_ISSUE;
          r_next     = 3'd0;
          c_next     = 3'd0;
          n_next     = 5'd0;
        end
      end
      S_ISSUE: begin
        n_next = n + 5'd1;
        if (last_node) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (emit) begin
          n_next = 5'd0;
          if (last_entry) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_ISSUE;
            if (last_col) begin
              c_next = 3'd0;
              r_next = r + 3'd1;
            end else begin
              c_next = c + 3'd1;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    r <= r_next;
    c <= c_next;
    n <= n_next;
    if (start) begin
      rows <= clamp_dim(cfg.num_rows);
      cols <= clamp_dim(cfg.num_cols);
      sym  <= cfg.symmetric;
      if (cfg.num_nodes == 5'd0) begin
        nodes <= 5'd1;
      end else if (int'(cfg.num_nodes) > MAX_NODES) begin
        nodes <= 5'(MAX_NODES);
      end else begin
        nodes <= cfg.num_nodes;
      end
    end
  end

`ifndef ASSERT_OFF
  a_emit_not_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> !stat.busy)
    else $error("entry emitted with products in flight");

  a_clear_on_first_node: assert property (@(posedge clk) disable iff (rst)
    ctl.acc_clear |-> (ctl.issue && !stat.busy))
    else $error("accumulator cleared with products in flight");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && ctl.last) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after the last entry");
`endif

endmodule

// ----- hw/rtl/qgm_dp.sv -----
// qgm_dp: weight and family stores, shared multiply-accumulate, result register
// depends on qgm_pkg and qgm_ram
module qgm_dp #(
  parameter int MAX_MEMBERS = 8,
  parameter int MAX_NODES   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  qgm_pkg::req_t      req,
  input  qgm_pkg::ctl_cmd_t  ctl,
  output qgm_pkg::dp_stat_t  stat,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output qgm_pkg::rsp_t      rsp_data
);

  localparam int SB   = (VALUE_WIDTH < 16) ? VALUE_WIDTH : 16;
  localparam int FDEP = MAX_MEMBERS * MAX_NODES;
  localparam int WAW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int FAW  = (FDEP > 1) ? $clog2(FDEP) : 1;
  localparam int EW   = qgm_pkg::ENTRY_W;

  logic           wr_ok, we_w, we_f, we_s;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [FAW-1:0] f_waddr, f_raddr, s_raddr;
  logic [SB-1:0]  wdata, w_rd, f_rd, s_rd;

  logic                   v1, v2, v3;
  logic signed [2*SB-1:0] p1;
  logic signed [SB-1:0]   s_d;
  logic signed [3*SB-1:0] p2;
  logic signed [EW-1:0]   acc;

  // store writes, out-of-range indexes are dropped
  assign wr_ok = ctl.store_wr && (int'(req.node) < MAX_NODES);
  assign we_w  = wr_ok && (req.cmd == qgm_pkg::CMD_WEIGHT);
  assign we_f  = wr_ok && (req.cmd == qgm_pkg::CMD_FIRST)
                 && (int'(req.member) < MAX_MEMBERS);
  assign we_s  = wr_ok && (req.cmd == qgm_pkg::CMD_SECOND)
                 && (int'(req.member) < MAX_MEMBERS);
  assign wdata   = req.value[SB-1:0];
  assign w_waddr = WAW'(req.node);
  assign f_waddr = FAW'(int'(req.member) * MAX_NODES + int'(req.node));

  assign w_raddr = WAW'(ctl.node);
  assign f_raddr = FAW'(int'(ctl.first_mbr) * MAX_NODES + int'(ctl.node));
  assign s_raddr = FAW'(int'(ctl.second_mbr) * MAX_NODES + int'(ctl.node));

  qgm_ram #(.WIDTH(SB), .DEPTH(MAX_NODES)) u_weight (
    .clk(clk), .we(we_w), .waddr(w_waddr), .wdata(wdata),
    .raddr(w_raddr), .rdata(w_rd)
  );

  qgm_ram #(.WIDTH(SB), .DEPTH(FDEP)) u_first (
    .clk(clk), .we(we_f), .waddr(f_waddr), .wdata(wdata),
    .raddr(f_raddr), .rdata(f_rd)
  );

  qgm_ram #(.WIDTH(SB), .DEPTH(FDEP)) u_second (
    .clk(clk), .we(we_s), .waddr(f_waddr), .wdata(wdata),
    .raddr(s_raddr), .rdata(s_rd)
  );

  // read, weight * first, * second, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2;
    end
    p1  <= $signed(w_rd) * $signed(f_rd);
    s_d <= $signed(s_rd);
    p2  <= p1 * s_d;
    if (ctl.acc_clear) begin
      acc <= '0;
    end else if (v3) begin
      acc <= acc + EW'(p2);
    end
  end

  assign stat.busy     = v1 || v2 || v3;
  assign stat.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (ctl.emit) begin
      rsp_data.row   <= ctl.row;
      rsp_data.col   <= ctl.col;
      rsp_data.entry <= acc;
      rsp_data.last  <= ctl.last;
    end
  end

`ifndef ASSERT_OFF
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> rsp_valid)
    else $error("emitted entry not presented");

  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten while stalled");
`endif

endmodule

// ----- hw/rtl/quadrature_gram_matrix.sv -----
// quadrature_gram_matrix: top level, configuration registers and wiring
// depends on qgm_pkg, qgm_ctrl, qgm_dp (and qgm_ram through qgm_dp)
//
// usage
//   request channel (req_valid/req_stall/req_data): write a weight, a first
//   family value or a second family value at a node, or start a compute.
//   a write request is taken while idle and produces nothing.
//   a compute request emits rows*cols entries on the response channel
//   (rsp_valid/rsp_stall/rsp_data), row-major, last set on the final one.
//   each entry is the sum over nodes of weight * first[row] * second[col]
//   (first[col] * second[row] below the diagonal in symmetric mode) on one
//   shared multiply-accumulate unit, one node per cycle; an entry passes
//   through node reads, two multiplier stages, accumulate and emit.
//   req_stall stays high until the last entry is loaded.
//   a stalled response holds its entry and the sequencer waits for it.
//   configuration port is always ready; write it only while idle.
//   reset (rst, synchronous) sets sizes to 8x8 with 16 nodes, non symmetric,
//   and empties the response register; store contents are undefined until
//   written.
module quadrature_gram_matrix #(
  parameter int MAX_MEMBERS = 8,
  parameter int MAX_NODES   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  qgm_pkg::req_t      req_data,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output qgm_pkg::rsp_t      rsp_data,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  qgm_pkg::cfg_idx_t  cfg_index,
  input  logic [4:0]         cfg_data
);

  qgm_pkg::cfg_t     cfg;
  qgm_pkg::ctl_cmd_t ctl;
  qgm_pkg::dp_stat_t stat;

  // registers are plain flops, taken any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_rows  <= 4'd8;
      cfg.num_cols  <= 4'd8;
      cfg.num_nodes <= 5'd16;
      cfg.symmetric <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qgm_pkg::CFG_NUM_ROWS:  cfg.num_rows  <= cfg_data[3:0];
        qgm_pkg::CFG_NUM_COLS:  cfg.num_cols  <= cfg_data[3:0];
        qgm_pkg::CFG_NUM_NODES: cfg.num_nodes <= cfg_data;
        qgm_pkg::CFG_SYMMETRIC: cfg.symmetric <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer: idle / issue node reads / drain and emit
  qgm_ctrl #(
    .MAX_MEMBERS(MAX_MEMBERS),
    .MAX_NODES  (MAX_NODES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_cmd  (req_data.cmd),
    .cfg      (cfg),
    .stat     (stat),
    .ctl      (ctl)
  );

  // stores, multiply-accumulate and response register
  qgm_dp #(
    .MAX_MEMBERS(MAX_MEMBERS),
    .MAX_NODES  (MAX_NODES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req_data),
    .ctl      (ctl),
    .stat     (stat),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

`ifndef ASSERT_OFF
  a_no_request_while_emitting: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> req_stall)
    else $error("request path open during a compute");
`endif

endmodule

// ----- verif/quadrature_gram_matrix_test.sv -----
// quadrature_gram_matrix_test: self-checking testbench for the quadrature gram matrix block
// needs qgm_pkg and quadrature_gram_matrix; drives requests, checks every gram entry
// against a predictor of its own and reports pass or fail
module quadrature_gram_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS   = 320;
  localparam int SETTLE_CYCLES = 24;    // long enough for the longest entry, at 16 nodes, to drain
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT    = 4000;  // cycles without any handshake

  // one line of the directed script: a register write, or a request with an
  // optional hand-computed entry for 1x1 single-node matrices
  typedef struct {
    bit                  is_cfg;
    qgm_pkg::cfg_idx_t   idx;
    logic [4:0]          cfg_val;
    qgm_pkg::req_t       req;
    bit                  typed;
    qgm_pkg::rsp_t       want;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  qgm_pkg::req_t     req_data = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  qgm_pkg::rsp_t     rsp_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  qgm_pkg::cfg_idx_t cfg_index = qgm_pkg::CFG_NUM_ROWS;
  logic [4:0]        cfg_data = '0;

  // predictor copy of the block: register values and the three stores,
  // with a flag per store entry so that no compute ever reads an unloaded one
  logic [3:0]                       cfg_rows = 4'd8;
  logic [3:0]                       cfg_cols = 4'd8;
  logic [4:0]                       cfg_nodes = 5'd16;
  bit                               cfg_sym = 1'b0;
  logic signed [qgm_pkg::VAL_W-1:0] node_weight [16];
  logic signed [qgm_pkg::VAL_W-1:0] first_val [8][16];
  logic signed [qgm_pkg::VAL_W-1:0] second_val [8][16];
  bit                               weight_set [16];
  bit                               first_set [8][16];
  bit                               second_set [8][16];

  qgm_pkg::rsp_t entries_due [$];   // gram entries still to come, oldest first
  script_row_t   script [$];
  int            errors = 0;
  int            entries_seen = 0;
  int            items_sent = 0;
  int            burst_left = 0;
  bit            req_idle = 1'b1;
  int            holds_asked = 0;
  int            holds_served = 0;
  int            quiet_cycles = 0;

  quadrature_gram_matrix uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // size registers saturate to 1..hi
  function automatic int clamp_size(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // exact sum over nodes of weight * first * second, low 52 bits
  function automatic logic signed [qgm_pkg::ENTRY_W-1:0] gram_entry(int f_mbr, int s_mbr,
                                                                  int n_nodes);
    longint acc;
    acc = 0;
    for (int n = 0; n < n_nodes; n++)
      acc += longint'(node_weight[n]) * longint'(first_val[f_mbr][n]) *
             longint'(second_val[s_mbr][n]);
    return acc[qgm_pkg::ENTRY_W-1:0];
  endfunction

  // row-major matrix for the current settings, lower triangle mirrored in
  // symmetric mode (first family of the column, second family of the row)
  task automatic predict_matrix();
    int            n_rows;
    int            n_cols;
    int            n_nodes;
    qgm_pkg::rsp_t e;
    n_rows  = clamp_size(cfg_rows, 8);
    n_cols  = clamp_size(cfg_cols, 8);
    n_nodes = clamp_size(cfg_nodes, 16);
    for (int r = 0; r < n_rows; r++) begin
      for (int c = 0; c < n_cols; c++) begin
        e.row   = 3'(r);
        e.col   = 3'(c);
        e.entry = (cfg_sym && c < r) ? gram_entry(c, r, n_nodes)
                                     : gram_entry(r, c, n_nodes);
        e.last  = (r == n_rows - 1) && (c == n_cols - 1);
        entries_due.push_back(e);
      end
    end
  endtask

  // update the predictor with one accepted request
  task automatic apply_request(qgm_pkg::req_t r);
    case (r.cmd)
      qgm_pkg::CMD_WEIGHT: begin
        node_weight[r.node] = r.value;
        weight_set[r.node]  = 1'b1;
      end
      qgm_pkg::CMD_FIRST: begin
        first_val[r.member][r.node] = r.value;
        first_set[r.member][r.node] = 1'b1;
      end
      qgm_pkg::CMD_SECOND: begin
        second_val[r.member][r.node] = r.value;
        second_set[r.member][r.node] = 1'b1;
      end
      default: predict_matrix();
    endcase
  endtask

  function automatic qgm_pkg::req_t make_req(qgm_pkg::cmd_t c, int m, int n,
                                             logic signed [qgm_pkg::VAL_W-1:0] v);
    qgm_pkg::req_t r;
    r.cmd    = c;
    r.member = 3'(m);
    r.node   = 4'(n);
    r.value  = v;
    return r;
  endfunction

  function automatic script_row_t cfg_step(qgm_pkg::cfg_idx_t idx, int v);
    script_row_t s;
    s = '{is_cfg: 1'b1, idx: idx, cfg_val: 5'(v), req: '0, typed: 1'b0, want: '0};
    return s;
  endfunction

  function automatic script_row_t req_step(qgm_pkg::cmd_t c, int m, int n,
                                           logic signed [qgm_pkg::VAL_W-1:0] v);
    script_row_t s;
    s = '{is_cfg: 1'b0, idx: qgm_pkg::CFG_NUM_ROWS, cfg_val: '0,
          req: make_req(c, m, n, v), typed: 1'b0, want: '0};
    return s;
  endfunction

  // compute on a 1x1 single-node matrix whose entry is known by hand
  function automatic script_row_t typed_step(logic signed [qgm_pkg::ENTRY_W-1:0] e);
    script_row_t s;
    s = req_step(qgm_pkg::CMD_COMPUTE, 0, 0, '0);
    s.typed = 1'b1;
    s.want  = '{row: 3'd0, col: 3'd0, entry: e, last: 1'b1};
    return s;
  endfunction

  // extremes half the time, otherwise any 16-bit pattern
  function automatic logic signed [qgm_pkg::VAL_W-1:0] pick_value();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return raw[15:0];
    endcase
  endfunction

  // store write mostly inside the region the current settings read,
  // sometimes anywhere
  function automatic qgm_pkg::req_t any_store_write();
    int m_hi;
    int n_hi;
    if ($urandom_range(0, 4) == 0) begin
      m_hi = 7;
      n_hi = 15;
    end else begin
      m_hi = clamp_size((cfg_rows > cfg_cols) ? cfg_rows : cfg_cols, 8) - 1;
      n_hi = clamp_size(cfg_nodes, 16) - 1;
    end
    return make_req(qgm_pkg::cmd_t'($urandom_range(0, 2)), $urandom_range(0, m_hi),
                    $urandom_range(0, n_hi), pick_value());
  endfunction

  // present one request; the sender works in bursts with random gaps
  task automatic offer_request(qgm_pkg::req_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        if (!req_idle) req_valid <= 1'b0;
        req_idle = 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    req_data  <= r;
    req_valid <= 1'b1;
    req_idle  = 1'b0;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic issue(qgm_pkg::req_t r);
    offer_request(r);
    apply_request(r);
  endtask

  // load every store entry the next compute reads and that is still unwritten
  task automatic load_missing();
    int n_rows;
    int n_cols;
    int n_nodes;
    int n_second;
    n_rows   = clamp_size(cfg_rows, 8);
    n_cols   = clamp_size(cfg_cols, 8);
    n_nodes  = clamp_size(cfg_nodes, 16);
    // mirrored entries read the second family at row indexes
    n_second = (cfg_sym && n_rows > n_cols) ? n_rows : n_cols;
    for (int n = 0; n < n_nodes; n++) begin
      if (!weight_set[n]) issue(make_req(qgm_pkg::CMD_WEIGHT, 0, n, pick_value()));
      for (int m = 0; m < n_rows; m++)
        if (!first_set[m][n]) issue(make_req(qgm_pkg::CMD_FIRST, m, n, pick_value()));
      for (int m = 0; m < n_second; m++)
        if (!second_set[m][n]) issue(make_req(qgm_pkg::CMD_SECOND, m, n, pick_value()));
    end
  endtask

  // stop offering, wait for every expected entry, then let the block settle
  task automatic go_idle();
    if (!req_idle) req_valid <= 1'b0;
    req_idle = 1'b1;
    while (entries_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only while the block is idle
  task automatic write_reg(qgm_pkg::cfg_idx_t idx, logic [4:0] v);
    go_idle();
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      qgm_pkg::CFG_NUM_ROWS:  cfg_rows = v[3:0];
      qgm_pkg::CFG_NUM_COLS:  cfg_cols = v[3:0];
      qgm_pkg::CFG_NUM_NODES: cfg_nodes = v;
      default:                cfg_sym = v[0];
    endcase
  endtask

  // receiver: stall pattern changing in random spans, plus long hold-offs
  // on request from the stimulus, counted here
  initial begin : stall_pattern
    int mode;
    int span;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(8, 80);
        end
        span--;
        case (mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 4) == 0);
          2: rsp_stall <= ($urandom_range(0, 9) < 7);
          default: rsp_stall <= (span % 4 == 0);
        endcase
      end
    end
  end

  // response check: each accepted entry against the oldest expectation
  always @(posedge clk) begin : check_entries
    qgm_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (entries_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected entry: row %0d col %0d entry %0d last %0b",
                   rsp_data.row, rsp_data.col, rsp_data.entry, rsp_data.last);
      end else begin
        want = entries_due.pop_front();
        if (rsp_data.row !== want.row || rsp_data.col !== want.col ||
            rsp_data.entry !== want.entry || rsp_data.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display({"entry %0d mismatch: expected row %0d col %0d entry %0d last %0b,",
                      " got row %0d col %0d entry %0d last %0b"},
                     entries_seen, want.row, want.col, want.entry, want.last,
                     rsp_data.row, rsp_data.col, rsp_data.entry, rsp_data.last);
        end
      end
      entries_seen++;
    end
  end

  // watchdog: any request, entry or register write counts as progress
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;

    // directed part: hand-checked extremes, then saturating sizes and the
    // mirrored lower triangle with rows beyond the column count
    script = '{
      cfg_step(qgm_pkg::CFG_NUM_ROWS, 1), cfg_step(qgm_pkg::CFG_NUM_COLS, 1),
      cfg_step(qgm_pkg::CFG_NUM_NODES, 1), cfg_step(qgm_pkg::CFG_SYMMETRIC, 0),
      // most negative cubed
      req_step(qgm_pkg::CMD_WEIGHT, 0, 0, 16'sh8000),
      req_step(qgm_pkg::CMD_FIRST, 0, 0, 16'sh8000),
      req_step(qgm_pkg::CMD_SECOND, 0, 0, 16'sh8000),
      typed_step(-52'sd35184372088832),
      // most positive cubed
      req_step(qgm_pkg::CMD_WEIGHT, 0, 0, 16'sh7fff),
      req_step(qgm_pkg::CMD_FIRST, 0, 0, 16'sh7fff),
      req_step(qgm_pkg::CMD_SECOND, 0, 0, 16'sh7fff),
      typed_step(52'sd35181150961663),
      // top member and node indexes
      req_step(qgm_pkg::CMD_FIRST, 7, 15, 16'shffff),
      req_step(qgm_pkg::CMD_SECOND, 7, 15, 16'sh0001),
      req_step(qgm_pkg::CMD_WEIGHT, 0, 15, 16'sh4000),
      // zero rows saturates up, oversize columns saturate down, symmetric
      cfg_step(qgm_pkg::CFG_NUM_ROWS, 0), cfg_step(qgm_pkg::CFG_NUM_COLS, 31),
      cfg_step(qgm_pkg::CFG_NUM_NODES, 2), cfg_step(qgm_pkg::CFG_SYMMETRIC, 31),
      req_step(qgm_pkg::CMD_COMPUTE, 7, 15, 16'sh7fff),
      // 8x1 symmetric: every lower entry mirrors past the column count
      cfg_step(qgm_pkg::CFG_NUM_ROWS, 31), cfg_step(qgm_pkg::CFG_NUM_COLS, 0),
      cfg_step(qgm_pkg::CFG_NUM_NODES, 0),
      req_step(qgm_pkg::CMD_COMPUTE, 0, 0, 16'sh0000)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_reg(script[i].idx, script[i].cfg_val);
      end else if (script[i].typed) begin
        offer_request(script[i].req);
        entries_due.push_back(script[i].want);
      end else begin
        if (script[i].req.cmd == qgm_pkg::CMD_COMPUTE) load_missing();
        issue(script[i].req);
      end
    end

    // random part: each phase sets the registers while idle, then runs
    // well-formed write/compute sequences with stray writes mixed in
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (phase == 0) begin
        // full 8x8 matrix while the receiver holds off: the result register
        // fills, the block stalls and later writes queue up behind it
        write_reg(qgm_pkg::CFG_NUM_ROWS, 5'd8);
        write_reg(qgm_pkg::CFG_NUM_COLS, 5'd8);
        write_reg(qgm_pkg::CFG_NUM_NODES, 5'd3);
        write_reg(qgm_pkg::CFG_SYMMETRIC, 5'($urandom_range(0, 1)));
        load_missing();
        holds_asked++;
        issue(make_req(qgm_pkg::CMD_COMPUTE, 0, 0, '0));
        repeat (4) issue(any_store_write());
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          // any register value, saturating cases included
          write_reg(qgm_pkg::CFG_NUM_ROWS, 5'($urandom_range(0, 31)));
          write_reg(qgm_pkg::CFG_NUM_COLS, 5'($urandom_range(0, 31)));
          write_reg(qgm_pkg::CFG_NUM_NODES, 5'($urandom_range(0, 31)));
          write_reg(qgm_pkg::CFG_SYMMETRIC, 5'($urandom_range(0, 31)));
        end else begin
          // small matrices keep computes short
          write_reg(qgm_pkg::CFG_NUM_ROWS, 5'($urandom_range(1, 4)));
          write_reg(qgm_pkg::CFG_NUM_COLS, 5'($urandom_range(1, 4)));
          write_reg(qgm_pkg::CFG_NUM_NODES, 5'($urandom_range(1, 6)));
          write_reg(qgm_pkg::CFG_SYMMETRIC, 5'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(0, 8)) issue(any_store_write());
          load_missing();
          // member, node and value are don't-care on a compute
          issue(make_req(qgm_pkg::CMD_COMPUTE, $urandom_range(0, 7),
                         $urandom_range(0, 15), pick_value()));
        end
      end
      phase++;
    end

    go_idle();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/qgm_pkg.sv
hw/rtl/qgm_ram.sv
hw/rtl/qgm_ctrl.sv
hw/rtl/qgm_dp.sv
hw/rtl/quadrature_gram_matrix.sv
verif/quadrature_gram_matrix_test.sv
